// File: rtl/prqs_pkg.sv
// Shared widths, mode codes and helper types for the priority ready-queue scheduler.
package prqs_pkg;

    localparam int MODE_W     = 2;
    localparam int TASK_ID_W  = 5;
    localparam int PRIO_W     = 8;
    localparam int OUT_LVL_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT     = 2'd0,
        MODE_READY    = 2'd1,
        MODE_SLEEP    = 2'd2,
        MODE_DISPATCH = 2'd3
    } t_mode;

endpackage

// File: rtl/prqs_req_if.sv
// Request channel interface: valid, ready and one scheduler command.
interface prqs_req_if;
    logic                            valid;
    logic                            ready;
    logic [prqs_pkg::MODE_W-1:0]     mode;
    logic [prqs_pkg::TASK_ID_W-1:0]  task_id;
    logic [prqs_pkg::PRIO_W-1:0]     task_priority;

    modport source (output valid, output mode, output task_id, output task_priority,
                    input ready);
    modport sink   (input valid, input mode, input task_id, input task_priority,
                    output ready);
endinterface

// File: rtl/prqs_rsp_if.sv
// Response channel interface: valid, ready and one scheduler result.
interface prqs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            dispatched;
    logic [prqs_pkg::TASK_ID_W-1:0]  chosen_task;
    logic [prqs_pkg::OUT_LVL_W-1:0]  chosen_level;

    modport source (output valid, output dispatched, output chosen_task, output chosen_level,
                    input ready);
    modport sink   (input valid, input dispatched, input chosen_task, input chosen_level,
                    output ready);
endinterface

// File: rtl/priority_ready_queue_scheduler_unit.sv
// Top level of the bitmap priority ready-queue scheduler with its list memories and sequencer.
//
// Usage: commands arrive on i_req as valid/ready transactions carrying a mode, a task
// number and a priority. Init unlinks the task and records a clamped priority, ready
// appends the task to the tail of its level's FIFO, sleep unlinks the task, and
// dispatch pops the head of the lowest-numbered flagged level. Every command yields
// exactly one transaction on o_rsp. The block takes one command at a time: i_req.ready
// is high only while the sequencer is idle. A non-dispatch command with an out-of-range
// task number goes straight to the final step; a dispatch that finds no flagged level,
// or a flagged level with nothing queued, goes from the find step to the final step.
// Init and sleep run the reads and unlink, ready adds an append step, and a popping
// dispatch first reads the head of its level. Steps are registered reads of the link,
// level, head and tail memories, then the write-back of the unlink and append steps.
// The result sits in an output register, so a new command may be accepted while the
// previous result waits; if the receiver stalls, the sequencer holds in its final step
// until the output register frees up. A synchronous active-low reset clears the queued
// flags, level occupancy bits, ready bitmap and control state; the list memories need
// no clearing because they are only read where valid.
module priority_ready_queue_scheduler_unit #(
    parameter int LEVELS = 32,
    parameter int TASKS  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    prqs_req_if.sink      i_req,
    prqs_rsp_if.source    o_rsp
);

    localparam int LW = $clog2(LEVELS);
    localparam int TW = (TASKS > 2) ? $clog2(TASKS) : 1;

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FIND   = 9'b000000010,
        S_DHEAD  = 9'b000000100,
        S_DTASK  = 9'b000001000,
        S_RD1    = 9'b000010000,
        S_RD2    = 9'b000100000,
        S_UNLINK = 9'b001000000,
        S_APPEND = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state                r_state, n_state;
    prqs_pkg::t_mode       r_mode, n_mode;
    logic [TW-1:0]         r_task, n_task;
    logic [LW-1:0]         r_prio, n_prio;
    logic [LW-1:0]         r_lv, n_lv;
    logic [TW-1:0]         r_tail_eff, n_tail_eff;
    logic                  r_res_disp, n_res_disp;
    logic [TW-1:0]         r_res_task, n_res_task;
    logic [LW-1:0]         r_res_lvl, n_res_lvl;

    logic [TASKS-1:0]      r_queued, n_queued;
    logic [LEVELS-1:0]     r_nonempty, n_nonempty;
    logic [LEVELS-1:0]     r_ready, n_ready;

    logic                  r_out_valid, n_out_valid;
    logic                  r_out_disp, n_out_disp;
    logic [prqs_pkg::TASK_ID_W-1:0] r_out_task, n_out_task;
    logic [prqs_pkg::OUT_LVL_W-1:0] r_out_lvl, n_out_lvl;

    // List memories and their registered read data.
    logic [LW-1:0]         r_mem_level [TASKS];
    logic [TW-1:0]         r_mem_next  [TASKS];
    logic [TW-1:0]         r_mem_prev  [TASKS];
    logic [TW-1:0]         r_mem_head  [LEVELS];
    logic [TW-1:0]         r_mem_tail  [LEVELS];

    logic [LW-1:0]         r_lvl_rd;
    logic [TW-1:0]         r_next_rd, r_prev_rd, r_head_rd, r_tail_rd;

    logic                  lvl_we, next_we, prev_we, head_we, tail_we;
    logic [TW-1:0]         lvl_waddr, next_waddr, prev_waddr;
    logic [LW-1:0]         head_waddr, tail_waddr, hl_raddr;
    logic [LW-1:0]         lvl_wdata;
    logic [TW-1:0]         next_wdata, prev_wdata, head_wdata, tail_wdata;

    logic                  req_fire, out_free;
    logic [LEVELS-1:0]     lowest_bit;
    logic [LW-1:0]         lowest_idx;
    logic                  cur_queued, is_head, is_tail, left_empty;

    assign req_fire = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.dispatched = r_out_disp;
    assign o_rsp.chosen_task  = r_out_task;
    assign o_rsp.chosen_level = r_out_lvl;

    // Lowest flagged level: isolate the lowest set bit, then encode it.
    assign lowest_bit = r_ready & (~r_ready + LEVELS'(1));
    always_comb begin
        lowest_idx = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (lowest_bit[i]) begin
                lowest_idx = lowest_idx | LW'(i);
            end
        end
    end

    assign hl_raddr   = (r_state == S_DHEAD) ? r_lv : r_lvl_rd;
    assign cur_queued = r_queued[r_task];
    assign is_head    = (r_head_rd == r_task);
    assign is_tail    = (r_tail_rd == r_task);
    assign left_empty = !r_nonempty[r_lv] || (cur_queued && is_head && is_tail);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_task      = r_task;
        n_prio      = r_prio;
        n_lv        = r_lv;
        n_tail_eff  = r_tail_eff;
        n_res_disp  = r_res_disp;
        n_res_task  = r_res_task;
        n_res_lvl   = r_res_lvl;
        n_queued    = r_queued;
        n_nonempty  = r_nonempty;
        n_ready     = r_ready;
        n_out_valid = r_out_valid;
        n_out_disp  = r_out_disp;
        n_out_task  = r_out_task;
        n_out_lvl   = r_out_lvl;

        lvl_we  = 1'b0;  lvl_waddr  = r_task;      lvl_wdata  = r_prio;
        next_we = 1'b0;  next_waddr = r_prev_rd;   next_wdata = r_next_rd;
        prev_we = 1'b0;  prev_waddr = r_next_rd;   prev_wdata = r_prev_rd;
        head_we = 1'b0;  head_waddr = r_lv;        head_wdata = r_next_rd;
        tail_we = 1'b0;  tail_waddr = r_lv;        tail_wdata = r_prev_rd;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_mode     = prqs_pkg::t_mode'(i_req.mode);
                    n_task     = TW'(i_req.task_id);
                    n_prio     = (32'(i_req.task_priority) >= LEVELS) ? LW'(LEVELS - 1)
                                                                      : LW'(i_req.task_priority);
                    n_res_disp = 1'b0;
                    n_res_task = '0;
                    n_res_lvl  = '0;
                    if (prqs_pkg::t_mode'(i_req.mode) == prqs_pkg::MODE_DISPATCH) begin
                        n_state = S_FIND;
                    end else if (32'(i_req.task_id) < TASKS) begin
                        n_state = S_RD1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FIND: begin
                if (r_ready == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_lv      = lowest_idx;
                    n_res_lvl = lowest_idx;
                    if (!r_nonempty[lowest_idx]) begin
                        // A flagged level with nothing queued just loses its bit.
                        n_ready[lowest_idx] = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DHEAD;
                    end
                end
            end
            S_DHEAD: begin
                n_state = S_DTASK;
            end
            S_DTASK: begin
                n_task  = r_head_rd;
                n_state = S_RD1;
            end
            S_RD1: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                n_lv    = r_lvl_rd;
                n_state = S_UNLINK;
            end
            S_UNLINK: begin
                if (cur_queued) begin
                    if (is_head) begin
                        head_we = 1'b1;
                    end else begin
                        next_we = 1'b1;
                    end
                    if (is_tail) begin
                        tail_we = 1'b1;
                    end else begin
                        prev_we = 1'b1;
                    end
                    if (is_head && is_tail) begin
                        n_nonempty[r_lv] = 1'b0;
                    end
                    n_queued[r_task] = 1'b0;
                end
                n_tail_eff = (cur_queued && is_tail) ? r_prev_rd : r_tail_rd;
                case (r_mode)
                    prqs_pkg::MODE_INIT: begin
                        lvl_we  = 1'b1;
                        n_state = S_DONE;
                    end
                    prqs_pkg::MODE_READY: begin
                        n_state = S_APPEND;
                    end
                    prqs_pkg::MODE_DISPATCH: begin
                        if (left_empty) begin
                            n_ready[r_lv] = 1'b0;
                        end
                        n_res_disp = 1'b1;
                        n_res_task = r_task;
                        n_res_lvl  = r_lv;
                        n_state    = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_APPEND: begin
                if (!r_nonempty[r_lv]) begin
                    head_we    = 1'b1;
                    head_wdata = r_task;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = r_tail_eff;
                    next_wdata = r_task;
                    prev_we    = 1'b1;
                    prev_waddr = r_task;
                    prev_wdata = r_tail_eff;
                end
                tail_we    = 1'b1;
                tail_wdata = r_task;
                n_nonempty[r_lv] = 1'b1;
                n_queued[r_task] = 1'b1;
                n_ready[r_lv]    = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                // Hold here while the receiver still owns the previous result.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_disp  = r_res_disp;
                    n_out_task  = prqs_pkg::TASK_ID_W'(r_res_task);
                    n_out_lvl   = prqs_pkg::OUT_LVL_W'(r_res_lvl);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_queued    <= '0;
            r_nonempty  <= '0;
            r_ready     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_queued    <= n_queued;
            r_nonempty  <= n_nonempty;
            r_ready     <= n_ready;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_task     <= n_task;
        r_prio     <= n_prio;
        r_lv       <= n_lv;
        r_tail_eff <= n_tail_eff;
        r_res_disp <= n_res_disp;
        r_res_task <= n_res_task;
        r_res_lvl  <= n_res_lvl;
        r_out_disp <= n_out_disp;
        r_out_task <= n_out_task;
        r_out_lvl  <= n_out_lvl;
    end

    // Per-task memories: level, forward link and backward link.
    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_mem_level[lvl_waddr] <= lvl_wdata;
        end
        r_lvl_rd <= r_mem_level[r_task];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_mem_next[next_waddr] <= next_wdata;
        end
        r_next_rd <= r_mem_next[r_task];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            r_mem_prev[prev_waddr] <= prev_wdata;
        end
        r_prev_rd <= r_mem_prev[r_task];
    end

    // Per-level memories: FIFO head and tail.
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_mem_head[head_waddr] <= head_wdata;
        end
        r_head_rd <= r_mem_head[hl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tail_we) begin
            r_mem_tail[tail_waddr] <= tail_wdata;
        end
        r_tail_rd <= r_mem_tail[hl_raddr];
    end

endmodule

// File: dv/prqs_sched_checker.sv
// Checker that predicts scheduler responses from observed commands and compares them.
`timescale 1ns / 100ps

module prqs_sched_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    prqs_req_if     i_req,
    prqs_rsp_if     i_rsp,
    output int      o_fail_count,
    output int      o_pending
);

    localparam int SCHED_LEVELS = 32;
    localparam int SCHED_TASKS  = 32;

    typedef struct packed {
        logic                           dispatched;
        logic [prqs_pkg::TASK_ID_W-1:0] chosen_task;
        logic [prqs_pkg::OUT_LVL_W-1:0] chosen_level;
    } t_sched_result;

    // Shadow copy of the scheduler's lists and bitmap.
    logic [4:0]              level_of [SCHED_TASKS];
    bit                      in_queue [SCHED_TASKS];
    logic [4:0]              link_nxt [SCHED_TASKS];
    logic [4:0]              link_prv [SCHED_TASKS];
    logic [4:0]              lvl_head [SCHED_LEVELS];
    logic [4:0]              lvl_tail [SCHED_LEVELS];
    int unsigned             lvl_count [SCHED_LEVELS];
    logic [SCHED_LEVELS-1:0] ready_map;

    t_sched_result awaited_results[$];
    int            mismatch_total;

    assign o_fail_count = mismatch_total;

    function automatic void detach_task(int unsigned t);
        int unsigned lv;
        int unsigned p;
        int unsigned n;
        if (!in_queue[t]) return;
        lv = level_of[t];
        p  = link_prv[t];
        n  = link_nxt[t];
        if (lvl_head[lv] == t) lvl_head[lv] = n;
        else link_nxt[p] = n;
        if (lvl_tail[lv] == t) lvl_tail[lv] = p;
        else link_prv[n] = p;
        if (lvl_count[lv] > 0) lvl_count[lv]--;
        in_queue[t] = 1'b0;
    endfunction

    function automatic void enqueue_at_tail(int unsigned t);
        int unsigned lv;
        lv = level_of[t];
        if (lvl_count[lv] == 0) begin
            lvl_head[lv] = t;
        end else begin
            link_nxt[lvl_tail[lv]] = t;
            link_prv[t] = lvl_tail[lv];
        end
        lvl_tail[lv] = t;
        lvl_count[lv]++;
        in_queue[t] = 1'b1;
        ready_map[lv] = 1'b1;
    endfunction

    function automatic t_sched_result predict_sched_result(prqs_pkg::t_mode mode,
                                                           logic [4:0] id,
                                                           logic [7:0] prio);
        t_sched_result res;
        int unsigned   lv;
        int unsigned   h;
        bit            found;
        res   = '0;
        found = 1'b0;
        lv    = 0;
        case (mode)
            prqs_pkg::MODE_DISPATCH: begin
                for (int i = 0; i < SCHED_LEVELS; i++) begin
                    if (!found && ready_map[i]) begin
                        found = 1'b1;
                        lv = i;
                    end
                end
                if (found) begin
                    res.chosen_level = lv[4:0];
                    if (lvl_count[lv] == 0) begin
                        ready_map[lv] = 1'b0;
                    end else begin
                        h = lvl_head[lv];
                        detach_task(h);
                        res.dispatched  = 1'b1;
                        res.chosen_task = h[4:0];
                        if (lvl_count[lv] == 0) ready_map[lv] = 1'b0;
                    end
                end
            end
            prqs_pkg::MODE_INIT: begin
                detach_task(id);
                level_of[id] = (prio >= SCHED_LEVELS) ? 5'(SCHED_LEVELS - 1) : prio[4:0];
            end
            prqs_pkg::MODE_READY: begin
                detach_task(id);
                enqueue_at_tail(id);
            end
            default: begin
                detach_task(id);
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: %s", $realtime, msg);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        t_sched_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SCHED_TASKS; i++) begin
                level_of[i] = '0;
                in_queue[i] = 1'b0;
                link_nxt[i] = '0;
                link_prv[i] = '0;
            end
            for (int i = 0; i < SCHED_LEVELS; i++) begin
                lvl_head[i]  = '0;
                lvl_tail[i]  = '0;
                lvl_count[i] = 0;
            end
            ready_map = '0;
            awaited_results.delete();
            o_pending <= 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("response transaction with no command outstanding");
                end else begin
                    want = awaited_results.pop_front();
                    if (i_rsp.dispatched !== want.dispatched)
                        report_mismatch($sformatf(
                            "response dispatched mismatch, expected %0d, observed %0d",
                            want.dispatched, i_rsp.dispatched));
                    if (i_rsp.chosen_task !== want.chosen_task)
                        report_mismatch($sformatf(
                            "response chosen_task mismatch, expected %0d, observed %0d",
                            want.chosen_task, i_rsp.chosen_task));
                    if (i_rsp.chosen_level !== want.chosen_level)
                        report_mismatch($sformatf(
                            "response chosen_level mismatch, expected %0d, observed %0d",
                            want.chosen_level, i_rsp.chosen_level));
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_results.push_back(predict_sched_result(
                    prqs_pkg::t_mode'(i_req.mode), i_req.task_id, i_req.task_priority));
            end
            o_pending <= awaited_results.size();
        end
    end

endmodule

// File: dv/tb_priority_ready_queue_scheduler_unit.sv
// Top of the scheduler testbench: clock, reset, command stimulus, response back-pressure.
`timescale 1ns / 100ps

module tb_priority_ready_queue_scheduler_unit;

    // Random command count after the directed section.
    localparam int RANDOM_ITEMS   = 400;
    // Cycles without any transaction on either channel before the run is declared hung.
    // The slowest legitimate quiet stretch is a long sender gap or a long receiver stall
    // plus a dispatch that pops a task, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 1000;
    // Settling time after the last response.
    localparam int DRAIN_CYCLES   = 24;

    logic i_clk;
    logic i_rst_n;

    prqs_req_if req_ch ();
    prqs_rsp_if rsp_ch ();

    int fail_count;
    int pending_count;

    // Tasks that have seen an init. A ready is only ever issued for one of these, since
    // readying a task with no recorded priority is not a legal use of the block.
    bit task_known [32];
    // While set, neither side inserts idle cycles, so back-to-back traffic is exercised.
    bit calm_phase;
    int quiet_cycles;

    priority_ready_queue_scheduler_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    prqs_sched_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Idle length for either side: mostly none or short, occasionally long; none in the calm phase.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm_phase) return 0;
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Priorities cluster on a few low levels so that FIFOs really hold several tasks,
    // with some spread over all levels and some above the top level to hit the clamp.
    function automatic logic [7:0] pick_priority();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 8'($urandom_range(0, 3));
        if (roll < 80) return 8'($urandom_range(0, 31));
        if (roll < 93) return 8'($urandom_range(32, 255));
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd31;
            2: return 8'd32;
            default: return 8'd255;
        endcase
    endfunction

    // Presents one command and returns right after the edge at which it was accepted.
    // The valid line is only lowered when a gap is inserted, so consecutive commands
    // without a gap keep valid high across the boundary.
    task automatic send_cmd(prqs_pkg::t_mode mode, logic [4:0] id, logic [7:0] prio);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= mode;
        req_ch.task_id       <= id;
        req_ch.task_priority <= prio;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        if (mode == prqs_pkg::MODE_INIT) task_known[id] = 1'b1;
    endtask

    // Holds the sender off until every outstanding response has been collected.
    task automatic wait_all_responses();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Response side back-pressure: random stalls between random-length ready windows.
    initial begin
        int unsigned hold;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = pick_gap();
            if (hold != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // Watchdog: any cycle with a transaction on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL priority_ready_queue_scheduler_unit");
                $finish;
            end
        end
    end

    initial begin
        prqs_pkg::t_mode mode;
        logic [4:0]      id;
        logic [7:0]      prio;
        int unsigned     roll;

        calm_phase   = 1'b0;
        foreach (task_known[i]) task_known[i] = 1'b0;

        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.mode          <= prqs_pkg::MODE_INIT;
        req_ch.task_id       <= '0;
        req_ch.task_priority <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed section. A dispatch with nothing flagged comes first, then a priority
        // far above the top level that must clamp to level 31.
        send_cmd(prqs_pkg::MODE_DISPATCH, 5'd31, 8'd255);
        send_cmd(prqs_pkg::MODE_INIT,     5'd0,  8'd255);
        send_cmd(prqs_pkg::MODE_INIT,     5'd1,  8'd5);
        send_cmd(prqs_pkg::MODE_INIT,     5'd2,  8'd5);
        send_cmd(prqs_pkg::MODE_INIT,     5'd31, 8'd0);
        // Ready of an already queued task moves it behind task 2 on level 5.
        send_cmd(prqs_pkg::MODE_READY,    5'd1,  8'd0);
        send_cmd(prqs_pkg::MODE_READY,    5'd2,  8'd0);
        send_cmd(prqs_pkg::MODE_READY,    5'd1,  8'd128);
        send_cmd(prqs_pkg::MODE_READY,    5'd0,  8'd0);
        send_cmd(prqs_pkg::MODE_DISPATCH, 5'd0,  8'd0);
        // Sleeping the last task on level 5 leaves its bit set; the next dispatch finds the
        // level empty, names it and clears the bit. A second sleep hits an unqueued task.
        send_cmd(prqs_pkg::MODE_SLEEP,    5'd1,  8'd0);
        send_cmd(prqs_pkg::MODE_DISPATCH, 5'd21, 8'd170);
        send_cmd(prqs_pkg::MODE_SLEEP,    5'd1,  8'd85);
        // Re-init of a queued task unlinks it and keeps the old level's bit set.
        send_cmd(prqs_pkg::MODE_INIT,     5'd3,  8'd7);
        send_cmd(prqs_pkg::MODE_READY,    5'd3,  8'd0);
        send_cmd(prqs_pkg::MODE_INIT,     5'd3,  8'd32);
        send_cmd(prqs_pkg::MODE_READY,    5'd31, 8'd0);
        send_cmd(prqs_pkg::MODE_READY,    5'd3,  8'd0);
        send_cmd(prqs_pkg::MODE_DISPATCH, 5'd0,  8'd0);
        send_cmd(prqs_pkg::MODE_DISPATCH, 5'd0,  8'd0);
        // Unlink from the middle of level 31: queue is 0, 3, 4 and task 3 goes to sleep.
        send_cmd(prqs_pkg::MODE_INIT,     5'd4,  8'd31);
        send_cmd(prqs_pkg::MODE_READY,    5'd4,  8'd0);
        send_cmd(prqs_pkg::MODE_SLEEP,    5'd3,  8'd0);
        send_cmd(prqs_pkg::MODE_DISPATCH, 5'd10, 8'd64);
        send_cmd(prqs_pkg::MODE_DISPATCH, 5'd10, 8'd64);
        send_cmd(prqs_pkg::MODE_DISPATCH, 5'd10, 8'd64);
        wait_all_responses();

        // Random section. Readies are aimed only at initialized tasks; a ready drawn for
        // an unknown task turns into its init, so traffic keeps filling the FIFOs.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) calm_phase = ($urandom_range(0, 3) == 0);
            if (n % 100 == 99) wait_all_responses();
            roll = $urandom_range(0, 99);
            id   = 5'($urandom_range(0, 31));
            prio = pick_priority();
            if (roll < 18) mode = prqs_pkg::MODE_INIT;
            else if (roll < 55) mode = task_known[id] ? prqs_pkg::MODE_READY
                                                      : prqs_pkg::MODE_INIT;
            else if (roll < 68) mode = prqs_pkg::MODE_SLEEP;
            else mode = prqs_pkg::MODE_DISPATCH;
            send_cmd(mode, id, prio);
        end

        calm_phase = 1'b0;
        wait_all_responses();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS priority_ready_queue_scheduler_unit");
        end else begin
            $display("FAIL priority_ready_queue_scheduler_unit");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/prqs_pkg.sv
rtl/prqs_req_if.sv
rtl/prqs_rsp_if.sv
rtl/priority_ready_queue_scheduler_unit.sv
dv/prqs_sched_checker.sv
dv/tb_priority_ready_queue_scheduler_unit.sv
